/* hdl/smx_pkg.sv */
// Shared types and constants for the stack machine executor.
// Opcode and status codes, stack cell commands and default sizes.
// No dependencies.
package smx_pkg;

   localparam int DEF_STACK_DEPTH = 16;
   localparam int DEF_NUM_VARS    = 16;
   localparam int DEF_DATA_WIDTH  = 32;

   localparam int OPCODE_WIDTH = 4;
   localparam int IMM_WIDTH    = 32;
   localparam int INDEX_WIDTH  = 4;
   localparam int PRINT_WIDTH  = 32;
   localparam int STATUS_WIDTH = 3;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_ICONST = 4'd0,
      OP_ISTORE = 4'd1,
      OP_ILOAD  = 4'd2,
      OP_IADD   = 4'd3,
      OP_ISUB   = 4'd4,
      OP_IMUL   = 4'd5,
      OP_IAND   = 4'd6,
      OP_IOR    = 4'd7,
      OP_IEQ    = 4'd8,
      OP_IGT    = 4'd9,
      OP_ILT    = 4'd10,
      OP_PRINT  = 4'd11,
      OP_STOP   = 4'd12
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK          = 3'd0,
      ST_STOPPED     = 3'd1,
      ST_UNDERFLOW   = 3'd2,
      ST_OVERFLOW    = 3'd3,
      ST_UNKNOWN     = 3'd4,
      ST_PRINT_EMPTY = 3'd5,
      ST_IGNORED     = 3'd6
   } status_type;

   // What a stack cell loads on the next edge.
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_ABOVE = 2'd1,
      CELL_BELOW = 2'd2
   } cell_cmd_type;

   // Index width for a table of n entries (at least one bit).
   function automatic int index_bits(input int n);
      index_bits = (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

/* hdl/stack_machine_executor.sv */
// Stack machine executor top level: intake stage, execute stage, output register.
// Depends on smx_pkg, smx_stack_cell and smx_var_file.
//
//   channel  | ports                                         | direction
//   ---------+-----------------------------------------------+----------
//   request  | req_valid req_stall req_opcode req_immediate  | in
//            | req_var_index                                 |
//   response | rsp_valid rsp_stall rsp_print_valid           | out
//            | rsp_print_value rsp_status rsp_halted         |
//
// One instruction per cycle sustained while rsp_stall is low. A transferred
// request is registered in the intake stage (with its variable read), then
// executed into the output register. The operand stack is a chain of cells
// with the top in cell 0, so every instruction reads only cells 0 and 1;
// pushes, pops and binary operations shift the rest. Reset clears the stack
// count, halt flag and variable valid bits. A stalled response holds the
// execute stage; the intake stage still takes one more request.
module stack_machine_executor #(
   parameter int STACK_DEPTH = smx_pkg::DEF_STACK_DEPTH,
   parameter int NUM_VARS    = smx_pkg::DEF_NUM_VARS,
   parameter int DATA_WIDTH  = smx_pkg::DEF_DATA_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [smx_pkg::OPCODE_WIDTH-1:0]      req_opcode,
   input  logic signed [smx_pkg::IMM_WIDTH-1:0]  req_immediate,
   input  logic [smx_pkg::INDEX_WIDTH-1:0]       req_var_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_print_valid,
   output logic signed [smx_pkg::PRINT_WIDTH-1:0] rsp_print_value,
   output logic [smx_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic                                  rsp_halted
);
   import smx_pkg::*;

   localparam int SLOT_W  = index_bits(NUM_VARS);
   localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
   localparam int NUM_IDX = 2 ** INDEX_WIDTH;

   // Handshake
   logic req_take;
   logic out_move;
   logic exec;

   // Intake stage
   logic                        s1_valid_ff;
   logic [OPCODE_WIDTH-1:0]     s1_op_ff;
   logic signed [IMM_WIDTH-1:0] s1_imm_ff;
   logic [SLOT_W-1:0]           s1_slot_ff;
   logic [SLOT_W-1:0]           slot_tab [NUM_IDX];
   logic [SLOT_W-1:0]           req_slot;
   logic [DATA_WIDTH-1:0]       var_rd_data;

   // Architectural state
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               halt_ff;
   logic               halt_in;

   // Execute decode
   logic                  do_push;
   logic                  do_pop;
   logic                  do_binop;
   logic                  var_we;
   logic [DATA_WIDTH-1:0] op_a;
   logic [DATA_WIDTH-1:0] op_b;
   logic [DATA_WIDTH-1:0] alu_result;
   logic [DATA_WIDTH-1:0] new_data;
   logic                  print_hit;
   status_type            status;
   logic                  full;
   logic                  empty;
   logic                  lt_two;

   // Stack chain
   logic [DATA_WIDTH-1:0] cell_q [STACK_DEPTH];
   cell_cmd_type          top_cmd;
   cell_cmd_type          rest_cmd;

   // Output register
   logic                         rsp_valid_ff;
   logic                         rsp_print_valid_ff;
   logic signed [PRINT_WIDTH-1:0] rsp_print_value_ff;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff;
   logic                         rsp_halted_ff;

   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign exec      = s1_valid_ff && out_move;
   assign req_stall = s1_valid_ff && !out_move;
   assign req_take  = req_valid && !req_stall;

   // Variable slot is the index modulo the file size, from a constant table.
   for (genvar g = 0; g < NUM_IDX; g++) begin : g_slot
      assign slot_tab[g] = SLOT_W'(g % NUM_VARS);
   end
   assign req_slot = slot_tab[req_var_index];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (exec) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_opcode;
         s1_imm_ff  <= req_immediate;
         s1_slot_ff <= req_slot;
      end
   end

   smx_var_file #(
      .NUM_VARS   (NUM_VARS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_var_file (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_slot (req_slot),
      .rd_data (var_rd_data),
      .wr_en   (var_we),
      .wr_slot (s1_slot_ff),
      .wr_data (cell_q[0])
   );

   assign op_a   = cell_q[0];
   assign op_b   = cell_q[1];
   assign full   = (count_ff == COUNT_W'(STACK_DEPTH));
   assign empty  = (count_ff == '0);
   assign lt_two = (count_ff < COUNT_W'(2));

   always_comb begin
      case (s1_op_ff)
         OP_IADD: alu_result = op_b + op_a;
         OP_ISUB: alu_result = op_b - op_a;
         OP_IMUL: alu_result = op_b * op_a;
         OP_IAND: alu_result = op_b & op_a;
         OP_IOR:  alu_result = op_b | op_a;
         OP_IEQ:  alu_result = DATA_WIDTH'(op_b == op_a);
         OP_IGT:  alu_result = DATA_WIDTH'($signed(op_b) > $signed(op_a));
         OP_ILT:  alu_result = DATA_WIDTH'($signed(op_b) < $signed(op_a));
         default: alu_result = '0;
      endcase
   end

   always_comb begin
      do_push   = 1'b0;
      do_pop    = 1'b0;
      do_binop  = 1'b0;
      print_hit = 1'b0;
      status    = ST_OK;
      halt_in   = halt_ff;
      if (halt_ff) begin
         status = ST_IGNORED;
      end else begin
         case (s1_op_ff)
            OP_ICONST, OP_ILOAD: begin
               if (full) begin
                  status  = ST_OVERFLOW;
                  halt_in = 1'b1;
               end else begin
                  do_push = 1'b1;
               end
            end
            OP_ISTORE: begin
               if (empty) begin
                  status  = ST_UNDERFLOW;
                  halt_in = 1'b1;
               end else begin
                  do_pop = 1'b1;
               end
            end
            OP_IADD, OP_ISUB, OP_IMUL, OP_IAND, OP_IOR, OP_IEQ, OP_IGT, OP_ILT: begin
               if (lt_two) begin
                  status  = ST_UNDERFLOW;
                  halt_in = 1'b1;
               end else begin
                  do_binop = 1'b1;
               end
            end
            OP_PRINT: begin
               if (empty) begin
                  status = ST_PRINT_EMPTY;
               end else begin
                  print_hit = 1'b1;
               end
            end
            OP_STOP: begin
               status  = ST_STOPPED;
               halt_in = 1'b1;
            end
            default: begin
               status  = ST_UNKNOWN;
               halt_in = 1'b1;
            end
         endcase
      end
   end

   assign var_we = exec && do_pop;

   always_comb begin
      if (s1_op_ff == OP_ICONST) begin
         new_data = DATA_WIDTH'(s1_imm_ff);
      end else if (s1_op_ff == OP_ILOAD) begin
         new_data = var_rd_data;
      end else begin
         new_data = alu_result;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop || do_binop) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   // Cell 0 takes new_data, or cell 1 on a pop; the rest shift as a push or pop.
   always_comb begin
      top_cmd  = CELL_HOLD;
      rest_cmd = CELL_HOLD;
      if (exec) begin
         if (do_push) begin
            top_cmd  = CELL_ABOVE;
            rest_cmd = CELL_ABOVE;
         end else if (do_binop) begin
            top_cmd  = CELL_ABOVE;
            rest_cmd = CELL_BELOW;
         end else if (do_pop) begin
            top_cmd  = CELL_BELOW;
            rest_cmd = CELL_BELOW;
         end
      end
   end

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] above;
      logic [DATA_WIDTH-1:0] below;
      if (g == 0) begin : g_top
         assign above = new_data;
      end else begin : g_mid
         assign above = cell_q[g-1];
      end
      if (g == STACK_DEPTH - 1) begin : g_bot
         assign below = cell_q[g];
      end else begin : g_up
         assign below = cell_q[g+1];
      end
      smx_stack_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cell_cmd   ((g == 0) ? top_cmd : rest_cmd),
         .above_data (above),
         .below_data (below),
         .cell_data  (cell_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec) begin
            count_ff <= count_in;
            halt_ff  <= halt_in;
         end
         if (out_move) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_print_valid_ff <= print_hit;
         rsp_print_value_ff <= print_hit ? PRINT_WIDTH'($signed(op_a)) : '0;
         rsp_status_ff      <= status;
         rsp_halted_ff      <= halt_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_print_valid = rsp_print_valid_ff;
   assign rsp_print_value = rsp_print_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_halted      = rsp_halted_ff;

endmodule

/* hdl/smx_stack_cell.sv */
// One entry of the operand stack chain.
// Loads from its upper or lower neighbor or holds; uses smx_pkg.
module smx_stack_cell #(
   parameter int DATA_WIDTH = smx_pkg::DEF_DATA_WIDTH
) (
   input  logic                       clock,
   input  smx_pkg::cell_cmd_type      cell_cmd,
   input  logic [DATA_WIDTH-1:0]      above_data,
   input  logic [DATA_WIDTH-1:0]      below_data,
   output logic [DATA_WIDTH-1:0]      cell_data
);
   import smx_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      case (cell_cmd)
         CELL_ABOVE: data_in = above_data;
         CELL_BELOW: data_in = below_data;
         default:    data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

/* hdl/smx_var_file.sv */
// Local variable file: memory with per-entry valid bits, registered read.
// An entry never written reads as zero; a same-edge write is forwarded. Uses smx_pkg.
module smx_var_file #(
   parameter int NUM_VARS   = smx_pkg::DEF_NUM_VARS,
   parameter int DATA_WIDTH = smx_pkg::DEF_DATA_WIDTH
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          rd_en,
   input  logic [smx_pkg::index_bits(NUM_VARS)-1:0]      rd_slot,
   output logic [DATA_WIDTH-1:0]                         rd_data,
   input  logic                                          wr_en,
   input  logic [smx_pkg::index_bits(NUM_VARS)-1:0]      wr_slot,
   input  logic [DATA_WIDTH-1:0]                         wr_data
);
   import smx_pkg::*;

   logic [DATA_WIDTH-1:0] mem [NUM_VARS];
   logic [NUM_VARS-1:0]   vld_ff;
   logic [DATA_WIDTH-1:0] mem_rd_ff;
   logic                  vld_rd_ff;
   logic                  fwd_ff;
   logic [DATA_WIDTH-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_slot];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         vld_rd_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_slot] <= 1'b1;
         end
         if (rd_en) begin
            vld_rd_ff <= vld_ff[rd_slot];
            fwd_ff    <= wr_en && (wr_slot == rd_slot);
         end
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (vld_rd_ff ? mem_rd_ff : '0);

endmodule
